FILE: hdl/rfscs_pkg.sv
// ----------------------------------------------------------------------------
// rfscs_pkg
// Shared types and constants of the remote socket code serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package rfscs_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int SYM_BYTES   = 12;   // frame bytes that carry a pattern symbol

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] MARK_BYTE  = 8'd128;

    localparam logic [7:0]  ONE_PATTERN_RST  = 8'd136;
    localparam logic [7:0]  ZERO_PATTERN_RST = 8'd142;
    localparam logic [15:0] BIT_TICKS_RST    = 16'd1;
    localparam logic [7:0]  REPEAT_RST       = 8'd10;

    typedef enum logic [1:0] {
        REG_ONE_PATTERN  = 2'd0,
        REG_ZERO_PATTERN = 2'd1,
        REG_BIT_TICKS    = 2'd2,
        REG_REPEAT_COUNT = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_TICK     = 2'd0,
        ST_SEND_OK  = 2'd1,
        ST_BAD_CODE = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    // classified item as it travels from front to back
    typedef struct packed {
        opcode_t     opcode;
        logic [5:0]  pin;
        logic        code_ok;
        logic [4:0]  house;     // 1 = character '1'
        logic [4:0]  device;    // one-hot device letter
        logic        switch_on;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  pin_out_index;
        logic        pin_level;
        logic        busy;
        logic        frame_done;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/rfscs_front.sv
// ----------------------------------------------------------------------------
// rfscs_front
// Classifies an incoming item: checks the code characters and reduces them
// to house bits and a one-hot device selector.
// ----------------------------------------------------------------------------
`default_nettype none

module rfscs_front (
    input  wire logic                  opcode,
    input  wire logic [5:0]            pin_index,
    input  wire logic [7:0]            char_a,
    input  wire logic [7:0]            char_b,
    input  wire logic [7:0]            char_c,
    input  wire logic [7:0]            char_d,
    input  wire logic [7:0]            char_e,
    input  wire logic [7:0]            device_letter,
    input  wire logic                  switch_on,
    output rfscs_pkg::cmd_t            cmd
);

    logic [4:0][7:0] chars;
    logic [4:0]      is_one;
    logic [4:0]      is_zero;
    logic [4:0]      dev_hot;
    logic            dev_ok;

    assign chars = {char_e, char_d, char_c, char_b, char_a};

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            is_one[k]  = (chars[k] == rfscs_pkg::CHAR_ONE);
            is_zero[k] = (chars[k] == rfscs_pkg::CHAR_ZERO);
            dev_hot[k] = (device_letter == rfscs_pkg::CHAR_A + 8'(k));
        end
    end

    assign dev_ok = (device_letter >= rfscs_pkg::CHAR_A) &&
                    (device_letter <= rfscs_pkg::CHAR_E);

    always_comb begin
        cmd.opcode    = rfscs_pkg::opcode_t'(opcode);
        cmd.pin       = pin_index;
        cmd.code_ok   = &(is_one | is_zero) && dev_ok;
        cmd.house     = is_one;
        cmd.device    = dev_hot;
        cmd.switch_on = switch_on;
    end

endmodule

`default_nettype wire

FILE: hdl/rfscs_queue.sv
// ----------------------------------------------------------------------------
// rfscs_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rfscs_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  rfscs_pkg::cmd_t      push_data,
    output logic                 not_full,
    input  wire logic            pop,
    output rfscs_pkg::cmd_t      pop_data,
    output logic                 not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    rfscs_pkg::cmd_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rfscs_back.sv
// ----------------------------------------------------------------------------
// rfscs_back
// Carries out classified items: holds the frame and transmit counters,
// the configuration registers, and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module rfscs_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              cmd_valid,
    input  rfscs_pkg::cmd_t        cmd,
    output logic                   cmd_pop,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output rfscs_pkg::result_t     res
);

    localparam int SYM = rfscs_pkg::SYM_BYTES;

    logic [7:0]     one_pat_reg, zero_pat_reg, repeat_cnt_reg;
    logic [15:0]    bit_ticks_reg;

    logic [SYM-1:0] sym_reg, sym_next;
    logic [7:0]     frame_one_reg, frame_one_next;
    logic [7:0]     frame_zero_reg, frame_zero_next;
    logic [3:0]     byte_pos_reg, byte_pos_next;
    logic [2:0]     bit_pos_reg, bit_pos_next;
    logic [7:0]     repeat_left_reg, repeat_left_next;
    logic [15:0]    tick_count_reg, tick_count_next;
    logic           active_reg, active_next;
    logic [5:0]     held_pin_reg, held_pin_next;

    logic           res_valid_reg;
    rfscs_pkg::result_t res_reg, res_next;

    logic [15:0]    sym_pad;
    logic [7:0]     cur_byte;
    logic           cur_level;
    logic [15:0]    hold;
    logic [16:0]    tick_inc;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_pat_reg    <= rfscs_pkg::ONE_PATTERN_RST;
            zero_pat_reg   <= rfscs_pkg::ZERO_PATTERN_RST;
            bit_ticks_reg  <= rfscs_pkg::BIT_TICKS_RST;
            repeat_cnt_reg <= rfscs_pkg::REPEAT_RST;
        end else if (cfg_we && cfg_index[7:2] == '0) begin
            unique case (rfscs_pkg::reg_idx_t'(cfg_index[1:0]))
                rfscs_pkg::REG_ONE_PATTERN:  one_pat_reg    <= cfg_data[7:0];
                rfscs_pkg::REG_ZERO_PATTERN: zero_pat_reg   <= cfg_data[7:0];
                rfscs_pkg::REG_BIT_TICKS:    bit_ticks_reg  <= cfg_data;
                rfscs_pkg::REG_REPEAT_COUNT: repeat_cnt_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // take the next item whenever the result register is free or draining
    assign cmd_pop   = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // current frame byte: patterns are captured when the send is accepted
    assign sym_pad = {{(16 - SYM){1'b0}}, sym_reg};
    always_comb begin
        if (byte_pos_reg < 4'(SYM)) begin
            cur_byte = sym_pad[byte_pos_reg] ? frame_one_reg : frame_zero_reg;
        end else if (byte_pos_reg == 4'(SYM)) begin
            cur_byte = rfscs_pkg::MARK_BYTE;
        end else begin
            cur_byte = '0;
        end
    end
    assign cur_level = active_reg && cur_byte[3'd7 - bit_pos_reg];

    assign hold     = (bit_ticks_reg == '0) ? 16'd1 : bit_ticks_reg;
    assign tick_inc = {1'b0, tick_count_reg} + 17'd1;

    always_comb begin
        sym_next         = sym_reg;
        frame_one_next   = frame_one_reg;
        frame_zero_next  = frame_zero_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        repeat_left_next = repeat_left_reg;
        tick_count_next  = tick_count_reg;
        active_next      = active_reg;
        held_pin_next    = held_pin_reg;
        res_next         = res_reg;

        if (cmd_pop) begin
            res_next.status     = rfscs_pkg::ST_TICK;
            res_next.pin_level  = 1'b0;
            res_next.frame_done = 1'b0;
            if (cmd.opcode == rfscs_pkg::OP_TICK) begin
                if (active_reg) begin
                    res_next.pin_level = cur_level;
                    tick_count_next    = tick_inc[15:0];
                    if (tick_inc >= {1'b0, hold}) begin
                        tick_count_next = '0;
                        bit_pos_next    = bit_pos_reg + 3'd1;
                        if (bit_pos_reg == 3'd7) begin
                            byte_pos_next = byte_pos_reg + 4'd1;
                            if (byte_pos_reg == 4'(rfscs_pkg::FRAME_BYTES - 1)) begin
                                repeat_left_next = repeat_left_reg - 8'd1;
                                if (repeat_left_reg == 8'd1) begin
                                    active_next         = 1'b0;
                                    res_next.frame_done = 1'b1;
                                end
                            end
                        end
                    end
                end
            end else if (active_reg) begin
                res_next.status    = rfscs_pkg::ST_BUSY;
                res_next.pin_level = cur_level;
            end else if (!cmd.code_ok) begin
                res_next.status = rfscs_pkg::ST_BAD_CODE;
            end else begin
                res_next.status  = rfscs_pkg::ST_SEND_OK;
                sym_next         = {!cmd.switch_on, cmd.switch_on, cmd.device, cmd.house};
                frame_one_next   = one_pat_reg;
                frame_zero_next  = zero_pat_reg;
                byte_pos_next    = '0;
                bit_pos_next     = '0;
                tick_count_next  = '0;
                repeat_left_next = (repeat_cnt_reg == '0) ? 8'd1 : repeat_cnt_reg;
                held_pin_next    = cmd.pin;
                active_next      = 1'b1;
            end
            res_next.pin_out_index = held_pin_next;
            res_next.busy          = active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg    <= '0;
            bit_pos_reg     <= '0;
            repeat_left_reg <= '0;
            tick_count_reg  <= '0;
            active_reg      <= 1'b0;
            held_pin_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            byte_pos_reg    <= byte_pos_next;
            bit_pos_reg     <= bit_pos_next;
            repeat_left_reg <= repeat_left_next;
            tick_count_reg  <= tick_count_next;
            active_reg      <= active_next;
            held_pin_reg    <= held_pin_next;
            if (cmd_pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg        <= sym_next;
        frame_one_reg  <= frame_one_next;
        frame_zero_reg <= frame_zero_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

FILE: hdl/rf_socket_code_serializer_unit.sv
// ----------------------------------------------------------------------------
// rf_socket_code_serializer_unit
// On/off keyed remote socket code transmitter: checks send commands, builds
// the 16-byte frame and shifts it out MSB first on tick items.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tdata, s_tuser (opcode)
//  m_*       out        m_tvalid/m_tready    m_tdata, m_tuser (status)
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while m_tready stays high; an item's result
//  passes the queue entry and then the result register before m_* offers it.
//  The front decodes codes without state; the back updates the transmit
//  counters once per item. A stalled m_ side fills the queue (QUEUE_DEPTH
//  items) before s_tready drops. Reset clears counters and queue; the
//  frame contents are rebuilt by every accepted send. Configuration is
//  always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rf_socket_code_serializer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pin_index[5:0], char_a[13:6], char_b[21:14], char_c[29:22], char_d[37:30],
    // char_e[45:38], device_letter[53:46], switch_on[54], zero pad[55]
    input  wire logic [55:0] s_tdata,
    // opcode[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pin_out_index[5:0], pin_level[6], busy_res[7], frame_done[8], zero pad[15:9]
    output logic [15:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    rfscs_pkg::cmd_t    front_cmd;
    rfscs_pkg::cmd_t    back_cmd;
    rfscs_pkg::result_t res;
    logic               q_not_full, q_not_empty, q_pop;

    assign cfg_ready = 1'b1;

    rfscs_front u_front (
        .opcode        (s_tuser[0]),
        .pin_index     (s_tdata[5:0]),
        .char_a        (s_tdata[13:6]),
        .char_b        (s_tdata[21:14]),
        .char_c        (s_tdata[29:22]),
        .char_d        (s_tdata[37:30]),
        .char_e        (s_tdata[45:38]),
        .device_letter (s_tdata[53:46]),
        .switch_on     (s_tdata[54]),
        .cmd           (front_cmd)
    );

    rfscs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_data  (back_cmd),
        .not_empty (q_not_empty)
    );

    assign s_tready = q_not_full;

    rfscs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (q_not_empty),
        .cmd       (back_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {7'b0, res.frame_done, res.busy, res.pin_level, res.pin_out_index};
    assign m_tuser = res.status;

    // a finished frame always leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> !m_tdata[7] && m_tuser == rfscs_pkg::ST_TICK)
        else $error("frame_done reported while still busy");

    // an accepted send starts a frame with the pin still low
    a_send_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfscs_pkg::ST_SEND_OK |-> m_tdata[7] && !m_tdata[6])
        else $error("accepted send without busy or with pin high");

    // rejection for a bad code only happens while idle
    a_bad_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfscs_pkg::ST_BAD_CODE |-> !m_tdata[7] && !m_tdata[6])
        else $error("bad code rejected while busy");

    // busy rejection only while a frame is running
    a_busy_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfscs_pkg::ST_BUSY |-> m_tdata[7] && !m_tdata[8])
        else $error("busy rejection while idle");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remote socket code serialiser. Commands and
// ticks stream in through a queue-fed driver. An in-bench transmitter model
// predicts status, pin, level, busy and done for every accepted item. A
// monitor compares each returned item against the oldest prediction. Both
// stream sides idle in random bursts. The pattern, tick and repeat
// registers step through several settings between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        rfscs_pkg::opcode_t op;
        logic [5:0]         pin;
        logic [4:0][7:0]    house;    // house[0] is char_a
        logic [7:0]         dev;
        logic               sw;
    } cmd_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // pin_index[5:0], char_a[13:6], char_b[21:14], char_c[29:22], char_d[37:30],
    // char_e[45:38], device_letter[53:46], switch_on[54], zero pad[55]
    logic [55:0] s_tdata   = '0;
    // opcode[0]
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // pin_out_index[5:0], pin_level[6], busy_res[7], frame_done[8], zero pad[15:9]
    logic [15:0] m_tdata;
    // status[1:0]
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    rf_socket_code_serializer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // transmitter model: configuration copy and state
    logic [7:0]  one_pat       = rfscs_pkg::ONE_PATTERN_RST;
    logic [7:0]  zero_pat      = rfscs_pkg::ZERO_PATTERN_RST;
    logic [15:0] ticks_per_bit = rfscs_pkg::BIT_TICKS_RST;
    logic [7:0]  frame_reps    = rfscs_pkg::REPEAT_RST;

    logic [7:0]  frame_bytes [rfscs_pkg::FRAME_BYTES];
    logic [3:0]  byte_idx  = '0;
    logic [2:0]  bit_idx   = '0;
    logic [7:0]  reps_left = '0;
    logic [15:0] hold_cnt  = '0;
    logic        tx_active = 1'b0;
    logic [5:0]  tx_pin    = '0;

    cmd_item_t           cmd_backlog [$];
    rfscs_pkg::result_t  tx_answers  [$];
    cmd_item_t           cur_cmd;

    int mismatch_count = 0;
    int checked_count  = 0;
    int src_gap        = 0;
    int sink_gap       = 0;
    int stall_left     = 0;
    int stall_asked    = 0;
    int stall_served   = 0;
    bit idle_on        = 1'b0;

    task automatic flag_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $display("[%0t] item %0d: %s expected %0d, got %0d",
                 $time, checked_count, field, want, got);
    endtask

    task automatic step_transmitter(input cmd_item_t c, output rfscs_pkg::result_t r);
        logic [15:0]        hold;
        logic [7:0]         dev_off;
        logic               lvl;
        logic               done;
        logic               ok;
        rfscs_pkg::status_t st;
        lvl  = 1'b0;
        done = 1'b0;
        st   = rfscs_pkg::ST_TICK;
        if (c.op == rfscs_pkg::OP_TICK) begin
            if (tx_active) begin
                hold     = (ticks_per_bit == 16'd0) ? 16'd1 : ticks_per_bit;
                lvl      = frame_bytes[byte_idx][3'd7 - bit_idx];
                hold_cnt = hold_cnt + 16'd1;
                if (hold_cnt >= hold) begin
                    hold_cnt = '0;
                    if (bit_idx < 3'd7) begin
                        bit_idx++;
                    end else begin
                        bit_idx = '0;
                        if (byte_idx < 4'(rfscs_pkg::FRAME_BYTES - 1)) begin
                            byte_idx++;
                        end else begin
                            byte_idx  = '0;
                            reps_left = reps_left - 8'd1;
                            if (reps_left == 8'd0) begin
                                tx_active = 1'b0;
                                done      = 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (tx_active) begin
            st  = rfscs_pkg::ST_BUSY;
            lvl = frame_bytes[byte_idx][3'd7 - bit_idx];
        end else begin
            ok = (c.dev >= rfscs_pkg::CHAR_A) && (c.dev <= rfscs_pkg::CHAR_E);
            for (int k = 0; k < 5; k++)
                if (c.house[k] != rfscs_pkg::CHAR_ZERO && c.house[k] != rfscs_pkg::CHAR_ONE)
                    ok = 1'b0;
            if (!ok) begin
                st = rfscs_pkg::ST_BAD_CODE;
            end else begin
                dev_off = c.dev - rfscs_pkg::CHAR_A;
                for (int k = 0; k < 5; k++) begin
                    frame_bytes[k]     = (c.house[k] == rfscs_pkg::CHAR_ONE) ?
                                         one_pat : zero_pat;
                    frame_bytes[5 + k] = (dev_off == 8'(k)) ? one_pat : zero_pat;
                end
                frame_bytes[10] = c.sw ? one_pat : zero_pat;
                frame_bytes[11] = c.sw ? zero_pat : one_pat;
                frame_bytes[12] = rfscs_pkg::MARK_BYTE;
                frame_bytes[13] = 8'd0;
                frame_bytes[14] = 8'd0;
                frame_bytes[15] = 8'd0;
                byte_idx  = '0;
                bit_idx   = '0;
                hold_cnt  = '0;
                reps_left = (frame_reps == 8'd0) ? 8'd1 : frame_reps;
                tx_pin    = c.pin;
                tx_active = 1'b1;
                st        = rfscs_pkg::ST_SEND_OK;
            end
        end
        r.status        = st;
        r.pin_out_index = tx_pin;
        r.pin_level     = lvl;
        r.busy          = tx_active;
        r.frame_done    = done;
    endtask

    // sender: hold an item until taken, otherwise idle or load the next one
    always @(posedge aclk) begin : driver
        rfscs_pkg::result_t ans;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_transmitter(cur_cmd, ans);
                tx_answers.push_back(ans);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (idle_on && cmd_backlog.size() != 0 &&
                             $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_cmd.sw, cur_cmd.dev, cur_cmd.house, cur_cmd.pin};
                    s_tuser  <= cur_cmd.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each item taken, then decide the next ready level
    always @(posedge aclk) begin : monitor
        rfscs_pkg::result_t want;
        logic               ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked_count++;
                if (tx_answers.size() == 0) begin
                    flag_mismatch("unexpected item, queue depth", 0, 1);
                end else begin
                    want = tx_answers.pop_front();
                    if (m_tuser != want.status)
                        flag_mismatch("status", want.status, m_tuser);
                    if (m_tdata[5:0] != want.pin_out_index)
                        flag_mismatch("pin_out_index", want.pin_out_index, m_tdata[5:0]);
                    if (m_tdata[6] != want.pin_level)
                        flag_mismatch("pin_level", want.pin_level, m_tdata[6]);
                    if (m_tdata[7] != want.busy)
                        flag_mismatch("busy_res", want.busy, m_tdata[7]);
                    if (m_tdata[8] != want.frame_done)
                        flag_mismatch("frame_done", want.frame_done, m_tdata[8]);
                end
            end
            ready_next = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (stall_asked != stall_served) begin
                stall_served++;
                stall_left = 299;
                ready_next = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 8);
                ready_next = 1'b0;
            end
            m_tready <= ready_next;
        end
    end

    function automatic logic [4:0][7:0] house_bits(input logic [4:0] b);
        logic [4:0][7:0] h;
        for (int k = 0; k < 5; k++)
            h[k] = b[k] ? rfscs_pkg::CHAR_ONE : rfscs_pkg::CHAR_ZERO;
        return h;
    endfunction

    function automatic logic [7:0] CHAR_B_OR_A();
        return rfscs_pkg::CHAR_A + 8'd1;
    endfunction

    function automatic logic [7:0] CHAR_C_OR_A();
        return rfscs_pkg::CHAR_A + 8'd2;
    endfunction

    function automatic logic [7:0] CHAR_D_OR_A();
        return rfscs_pkg::CHAR_A + 8'd3;
    endfunction

    task automatic push_cmd(input rfscs_pkg::opcode_t op, input logic [5:0] pin,
                            input logic [4:0][7:0] house, input logic [7:0] dev,
                            input logic sw);
        cmd_item_t c;
        c.op    = op;
        c.pin   = pin;
        c.house = house;
        c.dev   = dev;
        c.sw    = sw;
        cmd_backlog.push_back(c);
    endtask

    // mostly ticks and well-formed sends; a few corrupted codes
    task automatic queue_traffic(input int n);
        cmd_item_t c;
        int        r;
        for (int i = 0; i < n; i++) begin
            c.op  = rfscs_pkg::OP_TICK;
            c.pin = 6'($urandom_range(0, 63));
            for (int k = 0; k < 5; k++)
                c.house[k] = 8'($urandom_range(0, 255));
            c.dev = 8'($urandom_range(0, 255));
            c.sw  = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r >= 82) begin
                c.op    = rfscs_pkg::OP_SEND;
                c.house = house_bits(5'($urandom_range(0, 31)));
                c.dev   = rfscs_pkg::CHAR_A + 8'($urandom_range(0, 4));
                if (r >= 95) begin
                    if ($urandom_range(0, 1) == 1)
                        c.house[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
                    else
                        c.dev = 8'($urandom_range(0, 255));
                end
            end
            cmd_backlog.push_back(c);
        end
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_cmd(rfscs_pkg::OP_TICK, 6'($urandom_range(0, 63)), {$urandom, 8'($urandom)},
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input rfscs_pkg::reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= {6'd0, idx};
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rfscs_pkg::REG_ONE_PATTERN:  one_pat       = val[7:0];
            rfscs_pkg::REG_ZERO_PATTERN: zero_pat      = val[7:0];
            rfscs_pkg::REG_BIT_TICKS:    ticks_per_bit = val;
            rfscs_pkg::REG_REPEAT_COUNT: frame_reps    = val[7:0];
            default: ;
        endcase
    endtask

    // wait until every item is taken and answered, then let the pipe settle
    task automatic wait_drain();
        do @(posedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || tx_answers.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [4:0][7:0] good;
        logic [4:0][7:0] bad;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // reset patterns, single repetition
        write_reg(rfscs_pkg::REG_REPEAT_COUNT, 16'd1);
        good = house_bits(5'b10101);
        push_cmd(rfscs_pkg::OP_TICK, 6'd0, '0, 8'h00, 1'b0);
        push_cmd(rfscs_pkg::OP_TICK, 6'd63, '1, 8'hFF, 1'b1);
        bad = good; bad[0] = rfscs_pkg::CHAR_ONE + 8'd1;
        push_cmd(rfscs_pkg::OP_SEND, 6'd5, bad, rfscs_pkg::CHAR_A, 1'b1);
        bad = good; bad[4] = 8'hFF;
        push_cmd(rfscs_pkg::OP_SEND, 6'd5, bad, CHAR_B_OR_A(), 1'b0);
        bad = good; bad[2] = 8'h00;
        push_cmd(rfscs_pkg::OP_SEND, 6'd5, bad, rfscs_pkg::CHAR_E, 1'b1);
        bad = good; bad[1] = rfscs_pkg::CHAR_ZERO - 8'd1;
        push_cmd(rfscs_pkg::OP_SEND, 6'd5, bad, rfscs_pkg::CHAR_A, 1'b0);
        push_cmd(rfscs_pkg::OP_SEND, 6'd9, good, rfscs_pkg::CHAR_A - 8'd1, 1'b1);
        push_cmd(rfscs_pkg::OP_SEND, 6'd9, good, rfscs_pkg::CHAR_E + 8'd1, 1'b1);
        push_cmd(rfscs_pkg::OP_SEND, 6'd9, good, 8'h00, 1'b0);
        push_cmd(rfscs_pkg::OP_SEND, 6'd9, good, 8'hFF, 1'b0);
        push_cmd(rfscs_pkg::OP_SEND, 6'd63, good, rfscs_pkg::CHAR_E, 1'b1);
        push_cmd(rfscs_pkg::OP_SEND, 6'd1, house_bits(5'b01010), rfscs_pkg::CHAR_A, 1'b0);
        push_cmd(rfscs_pkg::OP_SEND, 6'd2, good, 8'hFF, 1'b1);
        queue_ticks(5);
        push_cmd(rfscs_pkg::OP_SEND, 6'd0, house_bits(5'b11111), CHAR_C_OR_A(), 1'b1);
        queue_ticks(2);
        queue_traffic(250);
        wait_drain();

        // all-ones against all-zeros patterns; zero ticks and repeats act as one
        write_reg(rfscs_pkg::REG_ONE_PATTERN, 16'h00FF);
        write_reg(rfscs_pkg::REG_ZERO_PATTERN, 16'h0000);
        write_reg(rfscs_pkg::REG_BIT_TICKS, 16'd0);
        write_reg(rfscs_pkg::REG_REPEAT_COUNT, 16'd0);
        stall_asked++;
        queue_traffic(350);
        wait_drain();

        // inverted patterns, slower bits, two repetitions, no idling
        idle_on = 1'b0;
        write_reg(rfscs_pkg::REG_ONE_PATTERN, 16'h0000);
        write_reg(rfscs_pkg::REG_ZERO_PATTERN, 16'h00FF);
        write_reg(rfscs_pkg::REG_BIT_TICKS, 16'd2);
        write_reg(rfscs_pkg::REG_REPEAT_COUNT, 16'd2);
        queue_traffic(500);
        wait_drain();

        // longest bit hold: the current bit must stay put
        idle_on = 1'b1;
        write_reg(rfscs_pkg::REG_BIT_TICKS, 16'hFFFF);
        write_reg(rfscs_pkg::REG_REPEAT_COUNT, 16'd1);
        push_cmd(rfscs_pkg::OP_SEND, 6'd42, house_bits(5'b00110), CHAR_B_OR_A(), 1'b0);
        queue_ticks(40);
        push_cmd(rfscs_pkg::OP_SEND, 6'd43, good, rfscs_pkg::CHAR_A, 1'b1);
        wait_drain();

        // back to single-tick bits; run any frame in flight to its end
        write_reg(rfscs_pkg::REG_ONE_PATTERN, 16'h005A);
        write_reg(rfscs_pkg::REG_ZERO_PATTERN, 16'h00A5);
        write_reg(rfscs_pkg::REG_BIT_TICKS, 16'd1);
        queue_traffic(200);
        queue_ticks(260);
        wait_drain();

        // longest repeat count, no idling to the end
        idle_on = 1'b0;
        write_reg(rfscs_pkg::REG_ONE_PATTERN, 16'h0081);
        write_reg(rfscs_pkg::REG_ZERO_PATTERN, 16'h007E);
        write_reg(rfscs_pkg::REG_REPEAT_COUNT, 16'd255);
        push_cmd(rfscs_pkg::OP_SEND, 6'd21, house_bits(5'b11001), CHAR_D_OR_A(), 1'b1);
        queue_traffic(180);
        wait_drain();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/rfscs_pkg.sv
hdl/rfscs_front.sv
hdl/rfscs_queue.sv
hdl/rfscs_back.sv
hdl/rf_socket_code_serializer_unit.sv
sim/tb_top.sv
